>>> src/floor_sum_linear_defines.svh
`ifndef FLOOR_SUM_LINEAR_DEFINES_SVH
`define FLOOR_SUM_LINEAR_DEFINES_SVH

// clocked assertion, quiet during reset
`define FSL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// assertion that also holds while reset is low
`define FSL_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> src/fsl_pkg.sv
package fsl_pkg;

  localparam int NW = 31;  // count / divisor / reduced slope and offset
  localparam int SW = 61;  // sum width
  localparam int PW = 64;  // unit product / dividend width
  localparam int TW = 62;  // a*n + b

  typedef enum logic {
    OP_MUL,
    OP_DIV
  } fsl_op_t;

  typedef struct packed {
    logic    start;
    fsl_op_t op;
    logic    long_div;  // 62-bit dividend, else 31-bit
  } fsl_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } fsl_stat_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_A_CHK,
    S_A_DIV,
    S_A_NN,
    S_A_MUL,
    S_B_CHK,
    S_B_DIV,
    S_B_MUL,
    S_T_MUL,
    S_T_CHK,
    S_T_DIV,
    S_OUT
  } fsl_state_t;

endpackage

>>> src/floor_sum_linear.sv
// An out-of-range beat goes from accept straight to S_OUT; any other beat works through the
// reduction states and repeats them once per Euclid role swap before it reaches S_OUT.
// One beat at a time: in_ready is high only while idle, so the next beat is accepted only
// after the result has been taken.
// The shared multiply/divide unit settles one bit per cycle. Reset (rst_n low, synchronous)
// returns to idle and drops any result.
module floor_sum_linear #(
  parameter int VALUE_BITS = 30
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [30:0] in_count,
  input  logic [30:0] in_divisor,
  input  logic [29:0] in_slope,
  input  logic [29:0] in_offset,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [60:0] out_sum,
  output logic        out_out_of_range
);
  import fsl_pkg::*;
  `include "floor_sum_linear_defines.svh"

  localparam int VB = (VALUE_BITS > 30) ? 30 : VALUE_BITS;
  localparam logic [29:0] VMASK = 30'((64'(1) << VB) - 64'(1));

  fsl_state_t    state_r, state_nxt;
  logic [NW-1:0] n_r, m_r, a_r, b_r, q_r;
  logic [SW-1:0] acc_r, half_r;
  logic [TW-1:0] top_r;
  logic          oor_r;

  fsl_req_t      req;
  fsl_stat_t     stat;
  logic [PW-1:0] opa, prod;
  logic [NW-1:0] opb, quot, rem;
  logic [NW-1:0] a_in, b_in;
  logic          bad_in, waiting, done;

  assign a_in   = {1'b0, in_slope & VMASK};
  assign b_in   = {1'b0, in_offset & VMASK};
  assign bad_in = (a_in >= in_divisor) || (b_in >= in_divisor);
  assign done   = stat.done;

  fsl_unit u_unit (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (req),
    .opa  (opa),
    .opb  (opb),
    .stat (stat),
    .prod (prod),
    .quot (quot),
    .rem  (rem)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_valid) state_nxt = bad_in ? S_OUT : S_A_CHK;
      S_A_CHK: state_nxt = (a_r >= m_r) ? S_A_DIV : S_B_CHK;
      S_A_DIV: if (done) state_nxt = S_A_NN;
      S_A_NN:  if (done) state_nxt = S_A_MUL;
      S_A_MUL: if (done) state_nxt = S_B_CHK;
      S_B_CHK: state_nxt = (b_r >= m_r) ? S_B_DIV : S_T_MUL;
      S_B_DIV: if (done) state_nxt = S_B_MUL;
      S_B_MUL: if (done) state_nxt = S_T_MUL;
      S_T_MUL: if (done) state_nxt = S_T_CHK;
      S_T_CHK: state_nxt = (top_r < {{(TW-NW){1'b0}}, m_r}) ? S_OUT : S_T_DIV;
      S_T_DIV: if (done) state_nxt = S_A_CHK;
      S_OUT:   if (out_ready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    waiting      = 1'b0;
    req.op       = OP_MUL;
    req.long_div = 1'b0;
    opa          = '0;
    opb          = '0;
    unique case (state_r)
      S_A_DIV: begin
        waiting = 1'b1;
        req.op  = OP_DIV;
        opa     = {{(PW-NW){1'b0}}, a_r};
        opb     = m_r;
      end
      S_A_NN: begin
        waiting = 1'b1;
        opa     = {{(PW-NW){1'b0}}, n_r};
        opb     = (n_r == '0) ? '0 : n_r - 1'b1;
      end
      S_A_MUL: begin
        waiting = 1'b1;
        opa     = {{(PW-SW){1'b0}}, half_r};
        opb     = q_r;
      end
      S_B_DIV: begin
        waiting = 1'b1;
        req.op  = OP_DIV;
        opa     = {{(PW-NW){1'b0}}, b_r};
        opb     = m_r;
      end
      S_B_MUL: begin
        waiting = 1'b1;
        opa     = {{(PW-NW){1'b0}}, n_r};
        opb     = q_r;
      end
      S_T_MUL: begin
        waiting = 1'b1;
        opa     = {{(PW-NW){1'b0}}, a_r};
        opb     = n_r;
      end
      S_T_DIV: begin
        waiting      = 1'b1;
        req.op       = OP_DIV;
        req.long_div = 1'b1;
        opa          = {{(PW-TW){1'b0}}, top_r};
        opb          = m_r;
      end
      default: waiting = 1'b0;
    endcase
    req.start = waiting && !stat.busy && !stat.done;
    in_ready  = (state_r == S_IDLE);
    out_valid = (state_r == S_OUT);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_valid) begin
      n_r   <= in_count;
      m_r   <= in_divisor;
      a_r   <= a_in;
      b_r   <= b_in;
      acc_r <= '0;
      oor_r <= bad_in;
    end
    if (done) begin
      unique case (state_r)
        S_A_DIV: begin
          q_r <= quot;
          a_r <= rem;
        end
        S_A_NN:  half_r <= prod[SW:1];  // n*(n-1)/2
        S_A_MUL: acc_r  <= acc_r + prod[SW-1:0];
        S_B_DIV: begin
          q_r <= quot;
          b_r <= rem;
        end
        S_B_MUL: acc_r <= acc_r + prod[SW-1:0];
        S_T_MUL: top_r <= prod[TW-1:0] + {{(TW-NW){1'b0}}, b_r};
        S_T_DIV: begin
          // swap roles of slope and divisor
          n_r <= quot;
          b_r <= rem;
          m_r <= a_r;
          a_r <= m_r;
        end
        default: ;
      endcase
    end
  end

  assign out_sum          = oor_r ? '0 : acc_r;
  assign out_out_of_range = oor_r;

  `FSL_ASSERT(a_done_in_wait, stat.done |-> waiting, "unit beat finished outside a wait state")
  `FSL_ASSERT(a_idle_unit, in_ready |-> !stat.busy, "unit busy while taking a new beat")
  `FSL_ASSERT(a_oor_zero, (out_valid && out_out_of_range) |-> (out_sum == '0), "oor with sum")
  `FSL_ASSERT(a_start_idle, req.start |=> stat.busy, "unit did not start")

endmodule

>>> src/fsl_unit.sv
module fsl_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  fsl_pkg::fsl_req_t             req,
  input  logic [fsl_pkg::PW-1:0]        opa,
  input  logic [fsl_pkg::NW-1:0]        opb,
  output fsl_pkg::fsl_stat_t            stat,
  output logic [fsl_pkg::PW-1:0]        prod,
  output logic [fsl_pkg::NW-1:0]        quot,
  output logic [fsl_pkg::NW-1:0]        rem
);
  import fsl_pkg::*;

  logic          busy_r, done_r;
  fsl_op_t       op_r;
  logic [5:0]    cnt_r, last_r;
  logic [PW-1:0] x_r, acc_r;
  logic [NW-1:0] y_r;

  logic [NW:0]   t;
  logic [PW-1:0] add_a, add_b, sum;
  logic          cin, ge;

  // one adder: accumulate for multiply, trial subtract for divide
  always_comb begin
    t = {acc_r[NW-1:0], x_r[TW-1]};
    if (op_r == OP_MUL) begin
      add_a = acc_r;
      add_b = x_r;
      cin   = 1'b0;
    end else begin
      add_a = {{(PW-NW-1){1'b0}}, t};
      add_b = ~{{(PW-NW){1'b0}}, y_r};
      cin   = 1'b1;
    end
    sum = add_a + add_b + {{(PW-1){1'b0}}, cin};
    ge  = ~sum[PW-1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        op_r   <= req.op;
        cnt_r  <= '0;
        acc_r  <= '0;
        y_r    <= opb;
        if (req.op == OP_MUL) begin
          x_r    <= opa;
          last_r <= 6'(NW - 1);
        end else if (req.long_div) begin
          x_r    <= {{(PW-TW){1'b0}}, opa[TW-1:0]};
          last_r <= 6'(TW - 1);
        end else begin
          x_r    <= {{(PW-TW){1'b0}}, opa[NW-1:0], {(TW-NW){1'b0}}};
          last_r <= 6'(NW - 1);
        end
      end else if (busy_r) begin
        if (op_r == OP_MUL) begin
          if (y_r[0]) acc_r <= sum;
          x_r <= {x_r[PW-2:0], 1'b0};
          y_r <= {1'b0, y_r[NW-1:1]};
        end else begin
          acc_r <= ge ? {{(PW-NW-1){1'b0}}, sum[NW:0]} : {{(PW-NW-1){1'b0}}, t};
          x_r   <= {x_r[PW-2:0], ge};
        end
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == last_r) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign prod      = acc_r;
  assign quot      = x_r[NW-1:0];
  assign rem       = acc_r[NW-1:0];

endmodule

>>> tb/sv/testbench.sv
module testbench;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [30:0] in_count = '0;
  logic [30:0] in_divisor = '0;
  logic [29:0] in_slope = '0;
  logic [29:0] in_offset = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [60:0] out_sum;
  logic        out_out_of_range;

  typedef struct {
    logic [60:0] sum;
    logic        oor;
  } floor_sum_t;

  typedef struct {
    logic [30:0] n;
    logic [30:0] m;
    logic [29:0] a;
    logic [29:0] b;
    bit          typed;
    logic [60:0] sum;
    logic        oor;
  } req_row_t;

  floor_sum_t sums_pending[$];
  int         errors = 0;
  bit         rx_hold = 1'b0;
  bit         rx_free = 1'b0;

  floor_sum_linear dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Euclid floor-sum, products wrap at 64 bits like the hardware
  function automatic floor_sum_t floor_sum(logic [30:0] cnt, logic [30:0] div,
                                           logic [29:0] slp, logic [29:0] ofs);
    floor_sum_t r;
    logic [63:0] n, m, a, b, acc, top, t;
    n = 64'(cnt); m = 64'(div); a = 64'(slp); b = 64'(ofs); acc = '0;
    r.oor = (a >= m) || (b >= m);
    if (r.oor) begin
      r.sum = '0;
      return r;
    end
    forever begin
      if (a >= m) begin
        acc += ((n * (n - (n > 0 ? 64'd1 : 64'd0))) / 64'd2) * (a / m);
        a = a % m;
      end
      if (b >= m) begin
        acc += n * (b / m);
        b = b % m;
      end
      top = a * n + b;
      if (top < m) break;
      n = top / m;
      b = top % m;
      t = m; m = a; a = t;
    end
    r.sum = acc[60:0];
    return r;
  endfunction

  // valid stays high into the next beat unless the sender idles
  task automatic send_beat(req_row_t row);
    floor_sum_t e;
    while (!rx_free && $urandom_range(99) < 20) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_count   <= row.n;
    in_divisor <= row.m;
    in_slope   <= row.a;
    in_offset  <= row.b;
    e = floor_sum(row.n, row.m, row.a, row.b);
    if (row.typed) begin
      e.sum = row.sum;
      e.oor = row.oor;
    end
    do @(posedge clk); while (!in_ready);
    sums_pending.push_back(e);
  endtask

  // mostly small counts/divisors so the Euclid loop stays short
  function automatic logic [30:0] pick31(int bits);
    return 31'($urandom) & 31'((32'd1 << bits) - 32'd1);
  endfunction

  function automatic req_row_t rand_row();
    req_row_t r;
    int w;
    r.typed = 1'b0;
    w = ($urandom_range(9) == 0) ? 31 : $urandom_range(1, 16);
    r.n = pick31(w);
    w = ($urandom_range(9) == 0) ? 30 : $urandom_range(1, 16);
    r.m = pick31(w);
    if ($urandom_range(9) == 0) r.m = pick31(31);
    if ($urandom_range(9) == 0) begin
      r.a = 30'($urandom);
      r.b = 30'($urandom);
    end else begin
      r.a = (r.m == 0) ? '0 : 30'($urandom % r.m);
      r.b = (r.m == 0) ? '0 : 30'($urandom % r.m);
    end
    return r;
  endfunction

  initial begin
    req_row_t dir[$];
    req_row_t r;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    //          n            m            a            b          typed sum oor
    dir.push_back('{31'd5, 31'd3, 30'd3, 30'd0, 1'b1, 61'd0, 1'b1});   // slope = divisor
    dir.push_back('{31'd5, 31'd3, 30'd0, 30'd7, 1'b1, 61'd0, 1'b1});   // offset above
    dir.push_back('{31'd5, 31'd0, 30'd0, 30'd0, 1'b1, 61'd0, 1'b1});   // zero divisor
    dir.push_back('{31'd0, 31'd7, 30'd3, 30'd2, 1'b1, 61'd0, 1'b0});   // empty sum
    dir.push_back('{31'd1, 31'd1, 30'd0, 30'd0, 1'b1, 61'd0, 1'b0});
    dir.push_back('{31'd10, 31'd1, 30'd0, 30'd0, 1'b1, 61'd0, 1'b0});
    dir.push_back('{31'd4, 31'd10, 30'd6, 30'd3, 1'b0, 61'd0, 1'b0});
    dir.push_back('{31'd6, 31'd5, 30'd4, 30'd4, 1'b0, 61'd0, 1'b0});
    dir.push_back('{31'h7fffffff, 31'h7fffffff, 30'h3fffffff, 30'h3fffffff,
                    1'b0, 61'd0, 1'b0});
    dir.push_back('{31'h7fffffff, 31'h40000000, 30'h3fffffff, 30'h3fffffff,
                    1'b0, 61'd0, 1'b0});
    dir.push_back('{31'h40000000, 31'h40000001, 30'h3fffffff, 30'h0, 1'b0, 61'd0, 1'b0});
    dir.push_back('{31'h7fffffff, 31'h7fffffff, 30'h0, 30'h0, 1'b1, 61'd0, 1'b0});
    dir.push_back('{31'h2aaaaaaa, 31'h55555555, 30'h15555555, 30'h2aaaaaaa,
                    1'b0, 61'd0, 1'b0});
    dir.push_back('{31'h55555555, 31'h2aaaaaab, 30'h2aaaaaaa, 30'h15555555,
                    1'b0, 61'd0, 1'b0});
    dir.push_back('{31'h7fffffff, 31'h1, 30'h3fffffff, 30'h0, 1'b1, 61'd0, 1'b1});
    dir.push_back('{31'd1000, 31'd997, 30'd996, 30'd996, 1'b0, 61'd0, 1'b0});
    foreach (dir[i]) send_beat(dir[i]);
    rx_free = 1'b1;                                 // no idling stretch
    repeat (30) send_beat(rand_row());
    rx_free = 1'b0;
    rx_hold = 1'b1;                                 // receiver holds off, input backs up
    repeat (3) send_beat(rand_row());
    rx_hold = 1'b0;
    repeat (40) send_beat(rand_row());
    in_valid <= 1'b0;
    while (sums_pending.size() != 0) @(posedge clk); // sender drains
    repeat (60) send_beat(rand_row());
    in_valid <= 1'b0;
    while (sums_pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

  initial begin
    int hold;
    forever begin
      @(posedge clk);
      if (rx_hold) begin
        out_ready <= 1'b0;
        for (hold = 0; hold < 3000; hold++) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= rx_free || ($urandom_range(99) >= 20);
      end
    end
  end

  always @(posedge clk) begin
    floor_sum_t e;
    if (rst_n && out_valid && out_ready) begin
      if (sums_pending.size() == 0) begin
        $display("%0t: result beat with nothing expected (sum %0d oor %0b)",
                 $time, out_sum, out_out_of_range);
        errors++;
      end else begin
        e = sums_pending.pop_front();
        if (out_sum !== e.sum) begin
          $display("%0t: sum expected %0d got %0d", $time, e.sum, out_sum);
          errors++;
        end
        if (out_out_of_range !== e.oor) begin
          $display("%0t: out_of_range expected %0b got %0b", $time, e.oor,
                   out_out_of_range);
          errors++;
        end
      end
    end
  end

  // Timeout covering ~150 items several times over the worst case
  initial begin
    #200000000;
    $display("Some tests failed");
    $finish;
  end

endmodule
